[hw/rtl/ttot_pkg.sv]
// shared types, codes and constant helpers for the tuple timestamp order table
`timescale 1ns / 1ps

package ttot_pkg;

   localparam int TYPE_W    = 3;
   localparam int SLOT_W    = 10;
   localparam int PORT_ID_W = 32;
   localparam int VIS_W     = 2;

   // request codes
   localparam logic [TYPE_W-1:0] OP_CHECK   = 3'd0;
   localparam logic [TYPE_W-1:0] OP_READ    = 3'd1;
   localparam logic [TYPE_W-1:0] OP_ACQUIRE = 3'd2;
   localparam logic [TYPE_W-1:0] OP_YIELD   = 3'd3;
   localparam logic [TYPE_W-1:0] OP_INSTALL = 3'd4;

   // visibility verdicts
   localparam logic [VIS_W-1:0] VIS_VISIBLE   = 2'd0;
   localparam logic [VIS_W-1:0] VIS_INVISIBLE = 2'd1;
   localparam logic [VIS_W-1:0] VIS_DELETED   = 2'd2;

   // reserved owner values
   localparam int OWNER_INVALID_CODE = 0;
   localparam int OWNER_FREE_CODE    = 1;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic read_direct;
      logic mem_read;
      logic mod_step;
      logic execute;
      logic clear_wr;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic direct;
      logic mod_done;
      logic clear_last;
   } sts_type;

   // largest shift k with slots << k still below the slot field range
   function automatic int max_shift(input int slots);
      int k;
      k = 0;
      for (int i = 1; i < SLOT_W; i++) begin
         if ((slots << i) < (1 << SLOT_W)) begin
            k = i;
         end
      end
      return k;
   endfunction

endpackage

[hw/rtl/ttot_ram.sv]
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module ttot_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/ttot_ctrl.sv]
// sequencing state machine for the tuple timestamp order table
`timescale 1ns / 1ps

module ttot_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ttot_pkg::cmd_type cmd,
   input  ttot_pkg::sts_type sts
);

   import ttot_pkg::*;

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_REDUCE = 3'd2;
   localparam logic [2:0] ST_LOOKUP = 3'd3;
   localparam logic [2:0] ST_EXEC   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (sts.direct) begin
                  cmd.mem_read    = 1'b1;
                  cmd.read_direct = 1'b1;
                  state_in        = ST_EXEC;
               end else begin
                  state_in = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            cmd.mod_step = 1'b1;
            if (sts.mod_done) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.mem_read = 1'b1;
            state_in     = ST_EXEC;
         end
         ST_EXEC: begin
            if (out_free) begin
               cmd.execute = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.execute || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_exec_needs_free_output: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over a waiting item");

   a_exec_raises_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |=> rsp_valid_ff)
      else $error("executed item not presented");

   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (!req_ready && !cmd.mem_read))
      else $error("table used before clearing finished");

   a_write_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.clear_wr && cmd.execute))
      else $error("clear and update write collide");

endmodule

[hw/rtl/ttot_dp.sv]
// datapath: request capture, slot reduction, table ram, update logic, result register
`timescale 1ns / 1ps

module ttot_dp #(
   parameter int SLOTS   = 1024,
   parameter int ID_BITS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  ttot_pkg::cmd_type                  cmd,
   output ttot_pkg::sts_type                  sts,
   input  logic [ttot_pkg::TYPE_W-1:0]        req_type,
   input  logic [ttot_pkg::SLOT_W-1:0]        req_slot,
   input  logic [ttot_pkg::PORT_ID_W-1:0]     req_txn_id,
   input  logic [ttot_pkg::PORT_ID_W-1:0]     req_txn_begin_cid,
   input  logic [ttot_pkg::PORT_ID_W-1:0]     req_new_owner,
   input  logic [ttot_pkg::PORT_ID_W-1:0]     req_new_begin_cid,
   input  logic [ttot_pkg::PORT_ID_W-1:0]     req_new_end_cid,
   input  logic                               req_clear_reader,
   output logic                               rsp_ok,
   output logic [ttot_pkg::VIS_W-1:0]         rsp_visibility,
   output logic                               rsp_is_owner,
   output logic                               rsp_is_ownable,
   output logic [ttot_pkg::PORT_ID_W-1:0]     rsp_slot_owner,
   output logic [ttot_pkg::PORT_ID_W-1:0]     rsp_reader_cid
);

   import ttot_pkg::*;

   localparam int AW        = $clog2(SLOTS);
   localparam int ROW_W     = 4 * ID_BITS;
   localparam bit IS_POW2   = (SLOTS & (SLOTS - 1)) == 0;
   localparam bit DIRECT    = IS_POW2 || (SLOTS >= (1 << SLOT_W));
   localparam int START_DIV = DIRECT ? 1 : (SLOTS << max_shift(SLOTS));

   localparam logic [ID_BITS-1:0] OWNER_FREE    = ID_BITS'(OWNER_FREE_CODE);
   localparam logic [ID_BITS-1:0] OWNER_INVALID = ID_BITS'(OWNER_INVALID_CODE);
   localparam logic [ID_BITS-1:0] MAX_CID       = '1;
   localparam logic [ID_BITS-1:0] CID_INVALID   = '0;
   localparam logic [ROW_W-1:0]   RESET_ROW     = {OWNER_INVALID, MAX_CID, MAX_CID,
                                                   {ID_BITS{1'b0}}};

   // captured request
   logic [TYPE_W-1:0]  op_ff;
   logic [ID_BITS-1:0] me_ff, mb_ff, nown_ff, nb_ff, ne_ff;
   logic               clr_ff;

   // slot reduction
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [SLOT_W-1:0] div_ff, div_in;

   // clearing sweep and table address
   logic [AW-1:0] clr_cnt_ff;
   logic [AW-1:0] addr_ff;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;
   logic [ROW_W-1:0] wr_data;
   logic [ROW_W-1:0] row;
   logic [ROW_W-1:0] new_row;

   logic [ID_BITS-1:0] own, b, e, r;
   logic [ID_BITS-1:0] own_n, r_n, b_n, e_n;
   logic               ok_n;
   logic [VIS_W-1:0]   vis_n, judge_v;
   logic               live;

   // result register
   logic               ok_ff, is_owner_ff, is_ownable_ff;
   logic [VIS_W-1:0]   vis_ff;
   logic [ID_BITS-1:0] owner_out_ff, reader_out_ff;

   always_comb begin
      idx_in = idx_ff;
      div_in = div_ff;
      if (cmd.capture) begin
         idx_in = req_slot;
         div_in = SLOT_W'(START_DIV);
      end else if (cmd.mod_step) begin
         if (idx_ff >= div_ff) begin
            idx_in = idx_ff - div_ff;
         end
         div_in = div_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      div_ff <= div_in;
      if (cmd.capture) begin
         op_ff   <= req_type;
         me_ff   <= ID_BITS'(req_txn_id);
         mb_ff   <= ID_BITS'(req_txn_begin_cid);
         nown_ff <= ID_BITS'(req_new_owner);
         nb_ff   <= ID_BITS'(req_new_begin_cid);
         ne_ff   <= ID_BITS'(req_new_end_cid);
         clr_ff  <= req_clear_reader;
      end
      if (cmd.mem_read) begin
         addr_ff <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear_wr) begin
         clr_cnt_ff <= clr_cnt_ff + AW'(1);
      end
   end

   assign sts.direct     = DIRECT;
   assign sts.mod_done   = (div_ff == SLOT_W'(SLOTS));
   assign sts.clear_last = (clr_cnt_ff == AW'(SLOTS - 1));

   assign rd_addr = cmd.read_direct ? AW'(req_slot) : AW'(idx_ff);
   assign wr_addr = cmd.clear_wr ? clr_cnt_ff : addr_ff;
   assign wr_data = cmd.clear_wr ? RESET_ROW : new_row;

   ttot_ram #(
      .WIDTH (ROW_W),
      .DEPTH (SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.clear_wr || cmd.execute),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.mem_read),
      .rd_addr (rd_addr),
      .rd_data (row)
   );

   assign own = row[4*ID_BITS-1:3*ID_BITS];
   assign b   = row[3*ID_BITS-1:2*ID_BITS];
   assign e   = row[2*ID_BITS-1:ID_BITS];
   assign r   = row[ID_BITS-1:0];

   // visibility verdict
   assign live = (mb_ff >= b) && !(mb_ff >= e);

   always_comb begin
      if (own == OWNER_INVALID) begin
         judge_v = live ? VIS_DELETED : VIS_INVISIBLE;
      end else if (own == me_ff) begin
         if (b == MAX_CID && e != CID_INVALID) begin
            judge_v = VIS_VISIBLE;
         end else if (e == CID_INVALID) begin
            judge_v = VIS_DELETED;
         end else begin
            judge_v = VIS_INVISIBLE;
         end
      end else if (own != OWNER_FREE && b == MAX_CID) begin
         judge_v = VIS_INVISIBLE;
      end else begin
         judge_v = live ? VIS_VISIBLE : VIS_INVISIBLE;
      end
   end

   // slot update
   always_comb begin
      own_n = own;
      b_n   = b;
      e_n   = e;
      r_n   = r;
      ok_n  = 1'b0;
      vis_n = VIS_VISIBLE;
      case (op_ff)
         OP_CHECK: begin
            ok_n  = 1'b1;
            vis_n = judge_v;
         end
         OP_READ: begin
            if (own == me_ff) begin
               ok_n = 1'b1;
            end else if (own == OWNER_FREE) begin
               if (r < mb_ff) begin
                  r_n = mb_ff;
               end
               ok_n = 1'b1;
            end
         end
         OP_ACQUIRE: begin
            if (r <= mb_ff && own == OWNER_FREE) begin
               own_n = me_ff;
               ok_n  = 1'b1;
            end
         end
         OP_YIELD: begin
            if (own == me_ff) begin
               own_n = OWNER_FREE;
               ok_n  = 1'b1;
            end
         end
         OP_INSTALL: begin
            own_n = nown_ff;
            b_n   = nb_ff;
            e_n   = ne_ff;
            if (clr_ff) begin
               r_n = '0;
            end
            ok_n = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign new_row = {own_n, b_n, e_n, r_n};

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         ok_ff         <= ok_n;
         vis_ff        <= vis_n;
         is_owner_ff   <= (own_n == me_ff);
         is_ownable_ff <= (own_n == OWNER_FREE) && (e_n > mb_ff);
         owner_out_ff  <= own_n;
         reader_out_ff <= r_n;
      end
   end

   assign rsp_ok         = ok_ff;
   assign rsp_visibility = vis_ff;
   assign rsp_is_owner   = is_owner_ff;
   assign rsp_is_ownable = is_ownable_ff;
   assign rsp_slot_owner = PORT_ID_W'(owner_out_ff);
   assign rsp_reader_cid = PORT_ID_W'(reader_out_ff);

endmodule

[hw/rtl/tuple_timestamp_order_table_unit.sv]
// top level of the tuple timestamp order table (mvcc metadata per slot)
`timescale 1ns / 1ps

// Per-slot MVCC metadata table. Each slot holds an owner id, begin and end
// commit ids and a last-reader commit id, kept in one SLOTS-deep table ram
// (4 * ID_BITS wide). After reset the block sweeps the table with its reset
// values, one slot per cycle, covering all SLOTS slots; req_ready stays low
// until the sweep is done. Each item is a read-modify-write of one slot. When
// SLOTS is a power of two or at least 1024, an item is accepted (table read
// issued) and then executed (update written back, result loaded); otherwise
// the slot index is first reduced modulo SLOTS by a compare-subtract loop and
// a lookup state then issues the table read before execute. The execute step
// waits while the previous result is still held on the rsp side; a new item
// can be accepted while a finished result waits. Ids are carried at ID_BITS
// inside and presented on 32-bit ports (zero-extended or truncated to fit on
// the way in and on the way out).

module tuple_timestamp_order_table_unit #(
   parameter int SLOTS   = 1024,
   parameter int ID_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   // request item
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [ttot_pkg::TYPE_W-1:0]    req_type,
   input  logic [ttot_pkg::SLOT_W-1:0]    req_slot,
   input  logic [ttot_pkg::PORT_ID_W-1:0] req_txn_id,
   input  logic [ttot_pkg::PORT_ID_W-1:0] req_txn_begin_cid,
   input  logic [ttot_pkg::PORT_ID_W-1:0] req_new_owner,
   input  logic [ttot_pkg::PORT_ID_W-1:0] req_new_begin_cid,
   input  logic [ttot_pkg::PORT_ID_W-1:0] req_new_end_cid,
   input  logic                           req_clear_reader,
   // result item
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_ok,
   output logic [ttot_pkg::VIS_W-1:0]     rsp_visibility,
   output logic                           rsp_is_owner,
   output logic                           rsp_is_ownable,
   output logic [ttot_pkg::PORT_ID_W-1:0] rsp_slot_owner,
   output logic [ttot_pkg::PORT_ID_W-1:0] rsp_reader_cid
);

   import ttot_pkg::*;

   // command and status between sequencer and datapath
   cmd_type cmd;
   sts_type sts;

   // sequencer: clearing sweep, accept, reduce, lookup, execute
   ttot_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // datapath: table ram, update logic and result register
   ttot_dp #(
      .SLOTS   (SLOTS),
      .ID_BITS (ID_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_type          (req_type),
      .req_slot          (req_slot),
      .req_txn_id        (req_txn_id),
      .req_txn_begin_cid (req_txn_begin_cid),
      .req_new_owner     (req_new_owner),
      .req_new_begin_cid (req_new_begin_cid),
      .req_new_end_cid   (req_new_end_cid),
      .req_clear_reader  (req_clear_reader),
      .rsp_ok            (rsp_ok),
      .rsp_visibility    (rsp_visibility),
      .rsp_is_owner      (rsp_is_owner),
      .rsp_is_ownable    (rsp_is_ownable),
      .rsp_slot_owner    (rsp_slot_owner),
      .rsp_reader_cid    (rsp_reader_cid)
   );

endmodule
